// ===== design/cfd_pkg.sv =====
package cfd_pkg;

  localparam int DATA_W  = 8;
  localparam int POS_W   = 10;
  localparam int CFG_W   = 11;
  localparam int LEN_W   = 16;

  localparam logic [DATA_W-1:0] START_BYTE = 8'h7E;
  localparam logic [DATA_W-1:0] SUM_GOOD   = 8'hFF;

  localparam int               MAX_FRAME_DEF = 1024;
  localparam logic [CFG_W-1:0] MAX_LEN_RST   = 11'd1024;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SUM  = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_ZERO_LEN = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN_HI  = 5'b00010,
    PH_LEN_LO  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

endpackage

// ===== design/cfd_if.sv =====
interface cfd_in_if;
  logic                         valid;
  logic                         ready;
  logic [cfd_pkg::DATA_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfd_out_if;
  logic                         valid;
  logic                         ready;
  logic [cfd_pkg::DATA_W-1:0]   data_byte;
  logic [cfd_pkg::POS_W-1:0]    position;
  logic                         frame_end;
  cfd_pkg::status_t             status;

  modport source (output valid, output data_byte, output position, output frame_end,
                  output status, input ready);
  modport sink   (input valid, input data_byte, input position, input frame_end,
                  input status, output ready);
endinterface

interface cfd_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [cfd_pkg::CFG_W-1:0]    max_payload_length;

  modport source (output valid, output max_payload_length, input ready);
  modport sink   (input valid, input max_payload_length, output ready);
endinterface

// ===== design/checksummed_frame_deframer.sv =====
// Frame deframer for a byte stream of the form 0x7E, length (16-bit big-endian),
// payload, checksum. Bytes before a start delimiter are dropped silently. Each
// payload byte comes out with its position (0 is the command byte); the checksum
// byte comes out with frame_end set and status ok or bad-sum (sum of payload and
// checksum must be 0xFF). A zero length, or one above the smaller of
// max_payload_length and MAX_FRAME, yields one error transaction on the low length
// byte and the deframer hunts again. One byte is taken every cycle while in_ch is not
// stalled: the frame state register and the output register both update when it is taken,
// and a result appears on out_ch in the cycle after its byte is taken. in_ch stalls only
// while a result sits unclaimed in the output register with out_ch.ready low.
// The cfg_ch write is always taken; a new maximum applies at the next length check.
module checksummed_frame_deframer #(
  parameter int MAX_FRAME = cfd_pkg::MAX_FRAME_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cfd_in_if.sink            in_ch,
  cfd_out_if.source         out_ch,
  cfd_cfg_if.sink           cfg_ch
);

  localparam int CNT_W = (MAX_FRAME < 2) ? 1 : $clog2(MAX_FRAME + 1);

  cfd_pkg::phase_t               phase_r, phase_nxt;
  logic [cfd_pkg::DATA_W-1:0]    len_hi_r, len_hi_nxt;
  logic [CNT_W-1:0]              length_r, length_nxt;
  logic [CNT_W-1:0]              bytes_seen_r, bytes_seen_nxt;
  logic [cfd_pkg::DATA_W-1:0]    sum_r, sum_nxt;
  logic [cfd_pkg::CFG_W-1:0]     max_len_r;

  logic                          out_valid_r, res_valid;
  logic [cfd_pkg::DATA_W-1:0]    out_data_r, res_data;
  logic [cfd_pkg::POS_W-1:0]     out_pos_r, res_pos;
  logic                          out_end_r, res_end;
  cfd_pkg::status_t              out_status_r, res_status;

  logic                          in_acc;
  logic [cfd_pkg::LEN_W-1:0]     len_full;
  logic [cfd_pkg::DATA_W-1:0]    sum_inc;
  logic [CNT_W:0]                seen_inc;
  logic                          too_long;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign len_full = {len_hi_r, in_ch.rx_byte};
  assign sum_inc  = sum_r + in_ch.rx_byte;
  assign seen_inc = {1'b0, bytes_seen_r} + 1'b1;
  // length field against the register and against the build-time ceiling
  assign too_long = (len_full > {5'd0, max_len_r}) ||
                    ({1'b0, len_full} > 17'(MAX_FRAME));

  always_comb begin
    phase_nxt      = phase_r;
    len_hi_nxt     = len_hi_r;
    length_nxt     = length_r;
    bytes_seen_nxt = bytes_seen_r;
    sum_nxt        = sum_r;
    res_valid      = 1'b0;
    res_data       = '0;
    res_pos        = '0;
    res_end        = 1'b0;
    res_status     = cfd_pkg::ST_OK;
    case (phase_r)
      cfd_pkg::PH_HUNT: begin
        if (in_ch.rx_byte == cfd_pkg::START_BYTE) begin
          phase_nxt      = cfd_pkg::PH_LEN_HI;
          bytes_seen_nxt = '0;
          sum_nxt        = '0;
        end
      end
      cfd_pkg::PH_LEN_HI: begin
        len_hi_nxt = in_ch.rx_byte;
        phase_nxt  = cfd_pkg::PH_LEN_LO;
      end
      cfd_pkg::PH_LEN_LO: begin
        if (len_full == '0) begin
          phase_nxt  = cfd_pkg::PH_HUNT;
          res_valid  = 1'b1;
          res_end    = 1'b1;
          res_status = cfd_pkg::ST_ZERO_LEN;
        end else if (too_long) begin
          phase_nxt  = cfd_pkg::PH_HUNT;
          res_valid  = 1'b1;
          res_end    = 1'b1;
          res_status = cfd_pkg::ST_TOO_LONG;
        end else begin
          // accepted length is at most MAX_FRAME, so it fits the counter
          length_nxt     = CNT_W'(len_full);
          bytes_seen_nxt = '0;
          sum_nxt        = '0;
          phase_nxt      = cfd_pkg::PH_PAYLOAD;
        end
      end
      cfd_pkg::PH_PAYLOAD: begin
        res_valid      = 1'b1;
        res_data       = in_ch.rx_byte;
        res_pos        = cfd_pkg::POS_W'(bytes_seen_r);
        sum_nxt        = sum_inc;
        bytes_seen_nxt = seen_inc[CNT_W-1:0];
        if (seen_inc >= {1'b0, length_r}) begin
          phase_nxt = cfd_pkg::PH_CHECK;
        end
      end
      cfd_pkg::PH_CHECK: begin
        sum_nxt    = sum_inc;
        res_valid  = 1'b1;
        res_data   = in_ch.rx_byte;
        res_end    = 1'b1;
        res_status = (sum_inc == cfd_pkg::SUM_GOOD) ? cfd_pkg::ST_OK : cfd_pkg::ST_BAD_SUM;
        phase_nxt  = cfd_pkg::PH_HUNT;
      end
      default: begin
        phase_nxt = cfd_pkg::PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= cfd_pkg::PH_HUNT;
      len_hi_r     <= '0;
      length_r     <= '0;
      bytes_seen_r <= '0;
      sum_r        <= '0;
    end else if (in_acc) begin
      phase_r      <= phase_nxt;
      len_hi_r     <= len_hi_nxt;
      length_r     <= length_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      sum_r        <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= cfd_pkg::MAX_LEN_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      max_len_r <= cfg_ch.max_payload_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_acc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_data_r   <= res_data;
      out_pos_r    <= res_pos;
      out_end_r    <= res_end;
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.data_byte = out_data_r;
  assign out_ch.position  = out_pos_r;
  assign out_ch.frame_end = out_end_r;
  assign out_ch.status    = out_status_r;

`ifndef SYNTHESIS
  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_end_r |-> out_status_r == cfd_pkg::ST_OK)
    else $error("payload transaction with non-ok status");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == cfd_pkg::ST_TOO_LONG ||
                    out_status_r == cfd_pkg::ST_ZERO_LEN)
    |-> out_end_r && out_data_r == '0 && out_pos_r == '0)
    else $error("length error transaction malformed");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == cfd_pkg::PH_PAYLOAD |-> bytes_seen_r < length_r)
    else $error("payload counter passed frame length");

  a_check_ends: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == cfd_pkg::PH_CHECK
    |=> out_valid_r && out_end_r && phase_r == cfd_pkg::PH_HUNT)
    else $error("checksum byte did not end the frame");

  a_hunt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && phase_r == cfd_pkg::PH_HUNT |=> !out_valid_r)
    else $error("result produced while hunting");
`endif

endmodule

// ===== tb/tb_checksummed_frame_deframer.sv =====
`timescale 1ns / 100ps

module tb_checksummed_frame_deframer;
  import cfd_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct {
    logic [DATA_W-1:0] data_byte;
    logic [POS_W-1:0]  position;
    logic              frame_end;
    status_t           status;
  } deframed_result_t;

  // Tracks the deframer's frame state and queues the transactions it should emit.
  class deframer_scoreboard;
    phase_t            phase;
    logic [LEN_W-1:0]  len_field;
    int                byte_count;
    logic [DATA_W-1:0] sum;
    logic [CFG_W-1:0]  max_len;
    deframed_result_t  awaited_results[$];
    int                errors;

    function new();
      phase      = PH_HUNT;
      len_field  = '0;
      byte_count = 0;
      sum        = '0;
      max_len    = MAX_LEN_RST;
      errors     = 0;
    endfunction

    function void set_max(logic [CFG_W-1:0] value);
      max_len = value;
    endfunction

    function int frame_limit();
      return (max_len > MAX_FRAME_DEF) ? MAX_FRAME_DEF : int'(max_len);
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void push(logic [DATA_W-1:0] d, logic [POS_W-1:0] p, logic e, status_t s);
      deframed_result_t r;
      r.data_byte = d;
      r.position  = p;
      r.frame_end = e;
      r.status    = s;
      awaited_results.push_back(r);
    endfunction

    function void take_byte(logic [DATA_W-1:0] b);
      case (phase)
        PH_HUNT: begin
          if (b == START_BYTE) begin
            phase      = PH_LEN_HI;
            len_field  = '0;
            byte_count = 0;
            sum        = '0;
          end
        end
        PH_LEN_HI: begin
          len_field = {b, 8'h00};
          phase     = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_field[7:0] = b;
          if (len_field == 0) begin
            push('0, '0, 1'b1, ST_ZERO_LEN);
            phase = PH_HUNT;
          end else if (int'(len_field) > frame_limit()) begin
            push('0, '0, 1'b1, ST_TOO_LONG);
            phase = PH_HUNT;
          end else begin
            byte_count = 0;
            sum        = '0;
            phase      = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          push(b, byte_count[POS_W-1:0], 1'b0, ST_OK);
          sum        = sum + b;
          byte_count = byte_count + 1;
          if (byte_count >= int'(len_field)) phase = PH_CHECK;
        end
        PH_CHECK: begin
          sum = sum + b;
          push(b, '0, 1'b1, (sum == SUM_GOOD) ? ST_OK : ST_BAD_SUM);
          phase = PH_HUNT;
        end
        default: phase = PH_HUNT;
      endcase
    endfunction

    function void check_result(logic [DATA_W-1:0] d, logic [POS_W-1:0] p, logic e, status_t s);
      deframed_result_t x;
      if (awaited_results.size() == 0) begin
        $error("unexpected transaction: data_byte %0h position %0d frame_end %0b status %0d",
               d, p, e, s);
        errors++;
        return;
      end
      x = awaited_results.pop_front();
      if (d !== x.data_byte) begin
        $error("data_byte: expected %0h, got %0h", x.data_byte, d);
        errors++;
      end
      if (p !== x.position) begin
        $error("position: expected %0d, got %0d", x.position, p);
        errors++;
      end
      if (e !== x.frame_end) begin
        $error("frame_end: expected %0b, got %0b", x.frame_end, e);
        errors++;
      end
      if (s !== x.status) begin
        $error("status: expected %0d, got %0d", x.status, s);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  cfd_in_if  in_ch ();
  cfd_out_if out_ch ();
  cfd_cfg_if cfg_ch ();

  checksummed_frame_deframer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  deframer_scoreboard frame_sb = new();

  int sent_bytes = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int ready_mode = 0;
  int mode_left = 0;
  int cycle_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Monitor: inputs are noted before results are checked on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) frame_sb.set_max(cfg_ch.max_payload_length);
      if (in_ch.valid && in_ch.ready) frame_sb.take_byte(in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready)
        frame_sb.check_result(out_ch.data_byte, out_ch.position, out_ch.frame_end,
                              out_ch.status);
    end
  end

  // Receiver back-pressure: switches between free-running, random, periodic and mostly stalled.
  always @(posedge clk) begin
    cycle_cnt++;
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (ready_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      2: out_ch.ready <= (cycle_cnt % 4) != 0;
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [DATA_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 16);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_header(input int payload_len);
    send_byte(START_BYTE);
    send_byte(payload_len[15:8]);
    send_byte(payload_len[7:0]);
  endtask

  task automatic send_frame(input int payload_len, input bit good_sum);
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] total;
    total = '0;
    send_header(payload_len);
    for (int k = 0; k < payload_len; k++) begin
      b = ($urandom_range(0, 7) == 0) ? START_BYTE : 8'($urandom);
      total = total + b;
      send_byte(b);
    end
    b = SUM_GOOD - total;
    if (!good_sum) b = b ^ 8'($urandom_range(1, 255));
    send_byte(b);
  endtask

  // Drain all outstanding results before touching the register.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frame_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_ch.valid              <= 1'b1;
    cfg_ch.max_payload_length <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_traffic(input int n_bytes);
    int first;
    int lim;
    int kind;
    int len;
    logic [DATA_W-1:0] b;
    first = sent_bytes;
    while (sent_bytes - first < n_bytes) begin
      lim  = frame_sb.frame_limit();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        if (lim == 0) begin
          send_header(1);
        end else begin
          len = $urandom_range(1, (lim < 12) ? lim : 12);
          if (lim > 12 && $urandom_range(0, 9) == 0)
            len = $urandom_range(13, (lim < 80) ? lim : 80);
          send_frame(len, $urandom_range(0, 4) != 0);
        end
      end else if (kind < 80) begin
        // line noise while hunting; keep it free of delimiters
        repeat ($urandom_range(1, 5)) begin
          b = 8'($urandom);
          if (b == START_BYTE) b = 8'h7D;
          send_byte(b);
        end
      end else if (kind < 87) begin
        send_header(0);
      end else if (kind < 94) begin
        send_header(($urandom_range(0, 1) == 0) ? lim + 1 : $urandom_range(lim + 1, 65535));
      end else begin
        // cut-short frame: whatever follows is swallowed as its payload
        len = $urandom_range(2, 12);
        send_header(len);
        repeat ($urandom_range(1, len - 1)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] max_seq [8];
    rst_n                     = 1'b0;
    in_ch.valid               = 1'b0;
    in_ch.rx_byte             = '0;
    out_ch.ready              = 1'b0;
    cfg_ch.valid              = 1'b0;
    cfg_ch.max_payload_length = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset maximum of 1024
    send_byte(8'h00);
    send_byte(8'hFF);
    send_header(0);
    send_header(16'hFFFF);
    send_header(1025);
    send_header(1);
    send_byte(START_BYTE);
    send_byte(SUM_GOOD - START_BYTE);
    send_header(1);
    send_byte(SUM_GOOD - START_BYTE);
    send_byte(START_BYTE);
    send_header(2);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h12);

    max_seq = '{11'd16, 11'd1, 11'd0, 11'd2047, 11'd1025, 11'd300,
                11'($urandom_range(2, 1024)), 11'd1024};
    foreach (max_seq[i]) begin
      write_max(max_seq[i]);
      random_traffic((max_seq[i] == 0) ? 30 : 70);
    end

    // long frame whose positions pass 255, then a length just past the limit
    send_frame(260, 1'b1);
    send_header(1025);
    send_frame(1, 1'b0);

    wait_drained();
    if (frame_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
